// File: design/handle_pool_allocator_defines.svh
// Assertion macros for the handle pool allocator.
`ifndef HANDLE_POOL_ALLOCATOR_DEFINES_SVH
`define HANDLE_POOL_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HPA_ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define HPA_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HPA_ASSERT_HOLDS(label, expr)
`define HPA_ASSERT_IMPLIES(label, ante, cons)
`define HPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/hpa_pkg.sv
package hpa_pkg;

  localparam int POOL_SIZE    = 256;
  localparam int HANDLE_W     = 8;
  localparam int MAP_DEPTH    = 1 << HANDLE_W;
  localparam int HANDLE_LIMIT = (POOL_SIZE < MAP_DEPTH) ? POOL_SIZE : MAP_DEPTH;
  localparam int CNT_W        = HANDLE_W + 1;

  localparam logic [CNT_W-1:0]    LIMIT_C    = CNT_W'(HANDLE_LIMIT);
  localparam logic [HANDLE_W-1:0] LAST_IDX_C = HANDLE_W'(HANDLE_LIMIT - 1);

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_TRY     = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NONE        = 2'd1;
  localparam logic [1:0] ST_BAD_RELEASE = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED   = 2'd3;

  typedef struct packed {
    logic pop_start;
    logic pop_finish;
    logic direct;
  } cmd_t;

  typedef struct packed {
    logic need_pop;
    logic out_free;
  } stat_t;

endpackage

// File: design/hpa_req_if.sv
interface hpa_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [hpa_pkg::HANDLE_W-1:0] handle;

  modport source (output valid, output kind, output handle, input ready);
  modport sink (input valid, input kind, input handle, output ready);
endinterface

// File: design/hpa_rsp_if.sv
interface hpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [hpa_pkg::HANDLE_W-1:0] granted;
  logic [1:0]                   status;

  modport source (output valid, output granted, output status, input ready);
  modport sink (input valid, input granted, input status, output ready);
endinterface

// File: design/hpa_ctrl.sv
module hpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hpa_pkg::stat_t stat,
  output hpa_pkg::cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd.pop_start  = 1'b0;
    cmd.pop_finish = 1'b0;
    cmd.direct     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.need_pop) begin
            cmd.pop_start = 1'b1;
            state_nxt     = S_WAIT;
          end else begin
            cmd.direct = 1'b1;
          end
        end
      end
      S_WAIT: begin
        // The free-list entry has been read; finish once the result slot is open.
        if (stat.out_free) begin
          cmd.pop_finish = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/hpa_datapath.sv
module hpa_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_kind,
  input  logic [hpa_pkg::HANDLE_W-1:0] in_handle,
  input  hpa_pkg::cmd_t                cmd,
  output hpa_pkg::stat_t               stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hpa_pkg::HANDLE_W-1:0] out_granted,
  output logic [1:0]                   out_status
);

  logic [hpa_pkg::HANDLE_W-1:0] free_list [hpa_pkg::MAP_DEPTH];
  logic [hpa_pkg::HANDLE_W-1:0] rd_data_r;
  logic [hpa_pkg::HANDLE_W-1:0] head_r, head_nxt;
  logic [hpa_pkg::HANDLE_W-1:0] tail_r, tail_nxt;
  logic [hpa_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [hpa_pkg::CNT_W-1:0]    fresh_r, fresh_nxt;
  logic [hpa_pkg::MAP_DEPTH-1:0] map_r, map_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [hpa_pkg::HANDLE_W-1:0] out_granted_r;
  logic [1:0]                   out_status_r;

  logic                         push_en;
  logic                         load_res;
  logic [hpa_pkg::HANDLE_W-1:0] res_granted;
  logic [1:0]                   res_status;
  logic                         is_alloc;

  assign is_alloc      = in_kind inside {hpa_pkg::KIND_ALLOC, hpa_pkg::KIND_TRY};
  assign stat.need_pop = is_alloc && (count_r != '0);
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    fresh_nxt   = fresh_r;
    map_nxt     = map_r;
    push_en     = 1'b0;
    load_res    = 1'b0;
    res_granted = '0;
    res_status  = hpa_pkg::ST_NONE;

    if (cmd.pop_start) begin
      head_nxt  = (head_r == hpa_pkg::LAST_IDX_C) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end

    if (cmd.pop_finish) begin
      load_res            = 1'b1;
      res_granted         = rd_data_r;
      res_status          = hpa_pkg::ST_OK;
      map_nxt[rd_data_r]  = 1'b1;
    end

    if (cmd.direct) begin
      load_res = 1'b1;
      case (in_kind)
        hpa_pkg::KIND_ALLOC: begin
          // Free list is empty here, so hand out a never-used handle.
          if (fresh_r < hpa_pkg::LIMIT_C) begin
            res_granted                             = fresh_r[hpa_pkg::HANDLE_W-1:0];
            res_status                              = hpa_pkg::ST_OK;
            map_nxt[fresh_r[hpa_pkg::HANDLE_W-1:0]] = 1'b1;
            fresh_nxt                               = fresh_r + 1'b1;
          end else begin
            res_status = hpa_pkg::ST_EXHAUSTED;
          end
        end
        hpa_pkg::KIND_TRY: begin
          res_status = hpa_pkg::ST_NONE;
        end
        hpa_pkg::KIND_RELEASE: begin
          if (({1'b0, in_handle} >= hpa_pkg::LIMIT_C) || !map_r[in_handle]) begin
            res_status = hpa_pkg::ST_BAD_RELEASE;
          end else begin
            res_status         = hpa_pkg::ST_OK;
            map_nxt[in_handle] = 1'b0;
            if (count_r < hpa_pkg::LIMIT_C) begin
              push_en   = 1'b1;
              tail_nxt  = (tail_r == hpa_pkg::LAST_IDX_C) ? '0 : tail_r + 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
        end
        default: res_status = hpa_pkg::ST_NONE;
      endcase
    end

    out_valid_nxt = out_valid_r;
    if (load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      free_list[tail_r] <= in_handle;
    end
    if (cmd.pop_start) begin
      rd_data_r <= free_list[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      out_granted_r <= res_granted;
      out_status_r  <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      map_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      map_r       <= map_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_status  = out_status_r;

endmodule

// File: design/handle_pool_allocator.sv
// Results: a result is registered when its item is accepted; a free-list pop reads the
// free-list memory into a register first and loads the result once the slot is open.
// Results wait in an output register. Throughput: one item per cycle for releases, try
// misses and fresh handles while the output slot is free; a free-list pop blocks new
// items until it finishes. Reset: synchronous, active low; pointers, counters and the
// in-use map clear, the free-list memory is not cleared and there is no clearing pass.
`include "handle_pool_allocator_defines.svh"

module handle_pool_allocator (
  input  logic      clk,
  input  logic      rst_n,
  hpa_req_if.sink   in_ch,
  hpa_rsp_if.source out_ch
);

  hpa_pkg::cmd_t  cmd;
  hpa_pkg::stat_t stat;

  hpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hpa_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_ch.kind),
    .in_handle   (in_ch.handle),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_granted (out_ch.granted),
    .out_status  (out_ch.status)
  );

  `HPA_ASSERT_IMPLIES(a_accept_needs_slot, in_ch.valid && in_ch.ready, !out_ch.valid || out_ch.ready)
  `HPA_ASSERT_NEXT(a_pop_blocks_input, cmd.pop_start, !in_ch.ready)
  `HPA_ASSERT_IMPLIES(a_fail_grants_zero, out_ch.valid && (out_ch.status != hpa_pkg::ST_OK), out_ch.granted == '0)
  `HPA_ASSERT_HOLDS(a_one_cmd, $onehot0({cmd.pop_start, cmd.pop_finish, cmd.direct}))

endmodule
